// File: design/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cleh_pkg.sv
// ----------------------------------------------------------------------------
// cleh_pkg
// Shared codes for the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none
package cleh_pkg;
  localparam logic [7:0] ChEsc = 8'h1b;
  localparam logic [7:0] ChLbr = 8'h5b;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChDel = 8'h7f;
  localparam logic [7:0] ChCw = 8'h17;
  localparam logic [7:0] ChCu = 8'h15;
  localparam logic [7:0] ChCr = 8'h12;
  localparam logic [7:0] ChCc = 8'h03;
  localparam logic [7:0] ChTilde = 8'h7e;
  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChRet = 8'h0d;
  localparam logic [7:0] ChUp = 8'h41;
  localparam logic [7:0] ChDown = 8'h42;
  localparam logic [7:0] ChZero = 8'h30;

  localparam logic [1:0] PfxNone = 2'd0;
  localparam logic [1:0] PfxErase = 2'd1;
  localparam logic [1:0] PfxReprint = 2'd2;
  localparam logic [1:0] PfxCancel = 2'd3;

  localparam logic [1:0] DstTerm = 2'd0;
  localparam logic [1:0] DstQueue = 2'd1;
  localparam logic [1:0] DstBoth = 2'd2;

  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscSeen = 2'd1;
  localparam logic [1:0] EscBrkt = 2'd2;
endpackage
`default_nettype wire

// File: design/console_line_editor_history_unit.sv
// ----------------------------------------------------------------------------
// console_line_editor_history_unit
// Line editor with a ring of history lines held in one text memory.
// ----------------------------------------------------------------------------
// Sequence: a byte is decoded first; for text results the memory read address
//   is set, then the read char is loaded into the output register, one text
//   word per memory read; a word erase first scans the line's chars back
//   through the same read port, and a submit checks for a "!" recall first.
// Throughput: one byte at a time; no new byte is taken until the last one's
//   result words are loaded, and output stalls hold the flow. The single
//   text memory read port sets the pace of text words.
// Reset: asynchronous, slot lengths, slot and escape phase clear; text memory
//   is not cleared (reads of unwritten text are undefined).
`default_nettype none
module console_line_editor_history_unit
  import cleh_pkg::*;
#(
  parameter int HISTORY_SLOTS = 8,
  parameter int LINE_LENGTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [1:0]      prefix_o,
  output logic [6:0]      erase_count_o,
  output logic            has_byte_o,
  output logic [7:0]      byte_value_o,
  output logic [1:0]      destination_o,
  output logic            prompt_after_o,
  output logic            newline_after_o,
  output logic [2:0]      slot_o,
  output logic            last_o
);
  localparam int SW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int CW = $clog2(LINE_LENGTH);
  localparam int LW = $clog2(LINE_LENGTH + 1);
  localparam int AW = SW + CW;
  localparam logic [SW-1:0] SlotMax = SW'(HISTORY_SLOTS - 1);
  localparam logic [LW-1:0] LenMax = LW'(LINE_LENGTH);

  typedef enum logic [3:0] {
    StIdle, StDecode, StWord, StBang, StBang2, StRd, StOut, StLone, StEnd
  } state_e;

  // text memory, one write and one registered read per cycle
  logic [7:0] mem_q [HISTORY_SLOTS*LINE_LENGTH];
  logic       mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd, rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  function automatic logic [AW-1:0] addr(logic [SW-1:0] s, logic [LW-1:0] i);
    return AW'(s) * AW'(LINE_LENGTH) + AW'(i);
  endfunction

  function automatic logic [SW-1:0] inc(logic [SW-1:0] s);
    return (s == SlotMax) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] dec(logic [SW-1:0] s);
    return (s == '0) ? SlotMax : s - 1'b1;
  endfunction

  state_e        st_q;
  logic [LW-1:0] len_q [HISTORY_SLOTS];
  logic [SW-1:0] slot_q, src_q;
  logic [1:0]    esc_q;
  logic [7:0]    byte_q;
  logic [LW-1:0] idx_q, cnt_q, wlen_q;
  logic [1:0]    mode_q;      // submit mode, 3 means plain echo
  logic          lone_prm_q;  // a lone result carries prompt_after
  logic          seen_sp_q;
  logic [1:0]    pfx_q;
  logic [6:0]    ers_q;
  logic          ers_done_q;
  logic          out_v_q;
  logic          out_load;    // output register takes a new word this cycle

  logic [LW-1:0] cur_len;
  assign cur_len = len_q[slot_q];

  assign rx_stall_o = (st_q != StIdle);
  assign res_valid_o = out_v_q;
  assign out_load = (st_q == StOut) ||
                    ((st_q == StLone || st_q == StEnd) && (!out_v_q || !res_stall_i));

  // read address follows the current scan
  always_comb begin
    mem_ra = addr(src_q, idx_q);
    if (st_q == StWord) mem_ra = addr(slot_q, wlen_q - 1'b1);
    if (st_q == StDecode || st_q == StBang) mem_ra = addr(slot_q, '0);
    if (st_q == StBang2) mem_ra = addr(slot_q, LW'(1));
  end

  // printable byte stored while the line has room, unless it continues an escape
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr(slot_q, cur_len);
    mem_wd = byte_q;
    if (st_q == StDecode && byte_q >= ChSpace && byte_q <= ChTilde && cur_len < LenMax &&
        !(esc_q == EscSeen && byte_q == ChLbr) &&
        !(esc_q == EscBrkt && (byte_q == ChUp || byte_q == ChDown))) mem_we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      for (int i = 0; i < HISTORY_SLOTS; i++) len_q[i] <= '0;
      slot_q <= '0;
      src_q <= '0;
      esc_q <= EscNone;
      out_v_q <= 1'b0;
      byte_q <= '0; idx_q <= '0; cnt_q <= '0; wlen_q <= '0; mode_q <= '0;
      lone_prm_q <= 1'b0; seen_sp_q <= 1'b0; pfx_q <= '0; ers_q <= '0;
      ers_done_q <= 1'b0;
      prefix_o <= '0; erase_count_o <= '0; has_byte_o <= 1'b0;
      byte_value_o <= '0; destination_o <= '0; prompt_after_o <= 1'b0;
      newline_after_o <= 1'b0; slot_o <= '0; last_o <= 1'b0;
    end else begin
      if (out_v_q && !res_stall_i && !out_load) out_v_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (rx_valid_i) begin
            byte_q <= rx_byte_i;
            pfx_q <= PfxNone;
            ers_q <= '0;
            st_q <= StDecode;
          end
        end
        StDecode: begin
          logic handled;
          logic [SW-1:0] ns;
          state_e nst;
          logic [1:0] nesc;
          handled = 1'b0;
          ns = (byte_q == ChUp) ? dec(slot_q) : inc(slot_q);
          nst = StIdle;
          nesc = EscNone;
          if (esc_q == EscSeen) begin
            if (byte_q == ChLbr) begin nesc = EscBrkt; handled = 1'b1; end
          end else if (esc_q == EscBrkt) begin
            if (byte_q == ChUp || byte_q == ChDown) begin
              handled = 1'b1;
              if (cur_len != '0) begin pfx_q <= PfxErase; ers_q <= 7'(cur_len); end
              slot_q <= ns;
              src_q <= ns;
              idx_q <= '0;
              if (len_q[ns] >= LenMax) begin
                mode_q <= 2'd2;
                cnt_q <= LenMax;
                nst = StRd;
              end else begin
                mode_q <= 2'd3;
                cnt_q <= len_q[ns];
                nst = (len_q[ns] != '0) ? StRd :
                      ((cur_len != '0) ? StLone : StIdle);
                lone_prm_q <= 1'b0;
              end
            end
          end else if (byte_q == ChEsc) begin
            nesc = EscSeen; handled = 1'b1;
          end
          if (!handled) begin
            lone_prm_q <= (byte_q == ChCc);
            if (byte_q == ChLf || byte_q == ChRet) begin
              mode_q <= 2'd0; nst = StBang;
            end else if (byte_q == ChBs || byte_q == ChDel) begin
              if (cur_len != '0) begin
                len_q[slot_q] <= cur_len - 1'b1;
                pfx_q <= PfxErase; ers_q <= 7'd1; nst = StLone;
              end
            end else if (byte_q == ChCw) begin
              wlen_q <= cur_len; cnt_q <= '0; seen_sp_q <= 1'b0; idx_q <= '0;
              nst = (cur_len != '0) ? StWord : StIdle;
            end else if (byte_q == ChCu) begin
              len_q[slot_q] <= '0;
              if (cur_len != '0) begin
                pfx_q <= PfxErase; ers_q <= 7'(cur_len); nst = StLone;
              end
            end else if (byte_q == ChCr) begin
              pfx_q <= PfxReprint; src_q <= slot_q; idx_q <= '0;
              cnt_q <= cur_len; mode_q <= 2'd3;
              nst = (cur_len != '0) ? StRd : StLone;
            end else if (byte_q == ChCc) begin
              len_q[slot_q] <= '0;
              pfx_q <= PfxCancel; nst = StLone;
            end else if (byte_q >= ChSpace && byte_q <= ChTilde) begin
              if (cur_len < LenMax) len_q[slot_q] <= cur_len + 1'b1;
              if (cur_len >= LenMax - 1'b1) begin
                mode_q <= 2'd1; nst = StBang;
              end else begin
                nst = StEnd;
              end
            end
          end
          st_q <= nst;
          esc_q <= nesc;
        end
        StWord: begin
          // idx_q 0: address of char wlen-1 out; idx_q 1: rd_q holds that char
          if (idx_q == '0) begin
            idx_q <= LW'(1);
          end else begin
            idx_q <= '0;
            if (seen_sp_q && rd_q != ChSpace) begin
              len_q[slot_q] <= wlen_q;
              pfx_q <= PfxErase; ers_q <= 7'(cnt_q); st_q <= StLone;
            end else begin
              if (rd_q == ChSpace) seen_sp_q <= 1'b1;
              wlen_q <= wlen_q - 1'b1;
              cnt_q <= cnt_q + 1'b1;
              if (wlen_q == LW'(1)) begin
                len_q[slot_q] <= '0;
                pfx_q <= PfxErase; ers_q <= 7'(cnt_q + 1'b1); st_q <= StLone;
              end
            end
          end
        end
        StBang: begin
          // char 0 read kept going so StBang2 sees it first
          src_q <= slot_q; idx_q <= '0; st_q <= StBang2;
        end
        StBang2: begin
          logic [SW-1:0] s;
          logic [LW-1:0] n;
          s = slot_q;
          n = cur_len;
          if (idx_q == '0) begin
            if (cur_len == 2 && rd_q == ChBang) begin
              idx_q <= LW'(1);
            end else begin
              idx_q <= LW'(2);
            end
          end
          if (idx_q == 1) begin
            if (rd_q >= ChZero && rd_q < ChZero + 8'(HISTORY_SLOTS)) s = SW'(rd_q - ChZero);
            else if (rd_q == ChBang) s = dec(slot_q);
            n = len_q[s];
          end
          if (idx_q != '0) begin
            slot_q <= s; src_q <= s; idx_q <= '0; cnt_q <= n;
            if (n != '0) st_q <= StRd;
            else begin
              len_q[s] <= '0; lone_prm_q <= 1'b1; st_q <= StLone;
            end
          end
        end
        StRd: begin
          if (!out_v_q || !res_stall_i) st_q <= StOut;
        end
        StOut: begin
          logic lst;
          lst = (idx_q == cnt_q - 1'b1);
          out_v_q <= 1'b1;
          prefix_o <= pfx_q; erase_count_o <= ers_q; pfx_q <= PfxNone; ers_q <= '0;
          has_byte_o <= 1'b1; byte_value_o <= rd_q;
          destination_o <= (mode_q == 2'd3) ? DstTerm :
                           (mode_q == 2'd2 || (mode_q == 2'd1 && lst)) ? DstBoth : DstQueue;
          prompt_after_o <= 1'b0;
          newline_after_o <= (mode_q != 2'd3) && lst;
          // a submit reports the slot it advances to on every word
          slot_o <= (mode_q == 2'd3) ? 3'(slot_q) : 3'(inc(slot_q));
          last_o <= lst;
          idx_q <= idx_q + 1'b1;
          st_q <= lst ? StIdle : StRd;
          if (lst && mode_q != 2'd3) begin
            slot_q <= inc(slot_q); len_q[inc(slot_q)] <= '0; esc_q <= EscNone;
          end
        end
        StLone: begin
          if (!out_v_q || !res_stall_i) begin
            out_v_q <= 1'b1;
            prefix_o <= pfx_q; erase_count_o <= ers_q;
            has_byte_o <= 1'b0; byte_value_o <= '0; destination_o <= DstTerm;
            prompt_after_o <= lone_prm_q; newline_after_o <= 1'b0; last_o <= 1'b1;
            slot_o <= 3'(slot_q);
            st_q <= StIdle;
          end
        end
        StEnd: begin
          if (!out_v_q || !res_stall_i) begin
            out_v_q <= 1'b1;
            prefix_o <= PfxNone; erase_count_o <= '0;
            has_byte_o <= 1'b1; byte_value_o <= byte_q; destination_o <= DstTerm;
            prompt_after_o <= 1'b0; newline_after_o <= 1'b0; last_o <= 1'b1;
            slot_o <= 3'(slot_q);
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/cleh_checker.sv
// ----------------------------------------------------------------------------
// cleh_checker
// Port-level checks for the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cleh_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       rx_valid_i,
  input wire logic       rx_stall_o,
  input wire logic       res_valid_o,
  input wire logic       res_stall_i,
  input wire logic       has_byte_o,
  input wire logic [7:0] byte_value_o,
  input wire logic [1:0] destination_o,
  input wire logic [1:0] prefix_o,
  input wire logic [6:0] erase_count_o
);
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, res_valid_o && res_stall_i, res_valid_o, "valid dropped")
  `ASSERT_NEXT(a_stable, clk_i, rst_ni, res_valid_o && res_stall_i,
    $stable(byte_value_o) && $stable(prefix_o) && $stable(erase_count_o), "stalled word changed")
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, rx_valid_i && !rx_stall_o, rx_stall_o, "no stall after accept")
  `ASSERT_IMPL(a_nobyte, clk_i, rst_ni, res_valid_o && !has_byte_o,
    byte_value_o == 8'd0 && destination_o == 2'd0, "empty word carries data")
  `ASSERT_IMPL(a_ers, clk_i, rst_ni, res_valid_o && prefix_o != 2'd1,
    erase_count_o == 7'd0, "erase count without erase")
endmodule

bind console_line_editor_history_unit cleh_checker u_cleh_checker (.*);
`default_nettype wire

// File: sim/console_line_editor_history_unit_tb.sv
// ----------------------------------------------------------------------------
// console_line_editor_history_unit_tb
// Self-checking bench for the console line editor: a short table of directed
// bytes, then random typed lines, edits, history moves, recalls and noise.
// Every accepted byte is run through a local model of the editor, and every
// result word is compared field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
`default_nettype none
module console_line_editor_history_unit_tb;
  import cleh_pkg::*;

  localparam int NSLOT = 8;
  localparam int LINE_MAX = 64;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  // one result word, as seen on the output ports
  typedef struct {
    logic [1:0] pfx;
    logic [6:0] erase;
    logic       has;
    logic [7:0] val;
    logic [1:0] dst;
    logic       prm;
    logic       nl;
    logic [2:0] slot;
    logic       last;
  } edit_word_t;

  // directed row: byte, and where cnt >= 0 the typed result count and the
  // first word's prefix / has_byte / byte_value
  typedef struct {
    logic [7:0] b;
    int         cnt;
    logic [1:0] pfx;
    logic       has;
    logic [7:0] val;
  } dir_row_t;

  localparam int NDIR = 28;
  dir_row_t dir_tab [0:NDIR-1] = '{
    '{ChRet,   1, PfxNone,   1'b0, 8'h00},  // empty submit: prompt only
    '{ChBs,    0, PfxNone,   1'b0, 8'h00},  // rub out on empty line
    '{8'h00,   0, PfxNone,   1'b0, 8'h00},  // null ignored
    '{8'h61,   1, PfxNone,   1'b1, 8'h61},
    '{ChTilde, 1, PfxNone,   1'b1, ChTilde},
    '{ChDel,   1, PfxErase,  1'b0, 8'h00},
    '{ChSpace, -1, PfxNone,  1'b0, 8'h00},
    '{8'h62,   -1, PfxNone,  1'b0, 8'h00},
    '{ChCw,    -1, PfxNone,  1'b0, 8'h00},
    '{ChCr,    -1, PfxNone,  1'b0, 8'h00},
    '{ChCu,    -1, PfxNone,  1'b0, 8'h00},
    '{8'h78,   -1, PfxNone,  1'b0, 8'h00},
    '{ChCc,    1, PfxCancel, 1'b0, 8'h00},
    '{ChEsc,   0, PfxNone,   1'b0, 8'h00},
    '{8'h78,   -1, PfxNone,  1'b0, 8'h00},  // ESC dropped, byte echoed
    '{ChEsc,   0, PfxNone,   1'b0, 8'h00},
    '{ChLbr,   0, PfxNone,   1'b0, 8'h00},
    '{8'h43,   -1, PfxNone,  1'b0, 8'h00},  // ESC [ dropped, C echoed
    '{ChLf,    -1, PfxNone,  1'b0, 8'h00},
    '{ChEsc,   0, PfxNone,   1'b0, 8'h00},
    '{ChLbr,   0, PfxNone,   1'b0, 8'h00},
    '{ChUp,    -1, PfxNone,  1'b0, 8'h00},
    '{ChBang,  -1, PfxNone,  1'b0, 8'h00},
    '{ChZero,  -1, PfxNone,  1'b0, 8'h00},
    '{ChRet,   -1, PfxNone,  1'b0, 8'h00},  // "!0" recall
    '{ChBang,  -1, PfxNone,  1'b0, 8'h00},
    '{ChBang,  -1, PfxNone,  1'b0, 8'h00},
    '{8'hff,   0, PfxNone,   1'b0, 8'h00}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i;
  logic       res_valid_o;
  logic       res_stall_i;
  logic [1:0] prefix_o;
  logic [6:0] erase_count_o;
  logic       has_byte_o;
  logic [7:0] byte_value_o;
  logic [1:0] destination_o;
  logic       prompt_after_o;
  logic       newline_after_o;
  logic [2:0] slot_o;
  logic       last_o;

  console_line_editor_history_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .prefix_o       (prefix_o),
    .erase_count_o  (erase_count_o),
    .has_byte_o     (has_byte_o),
    .byte_value_o   (byte_value_o),
    .destination_o  (destination_o),
    .prompt_after_o (prompt_after_o),
    .newline_after_o(newline_after_o),
    .slot_o         (slot_o),
    .last_o         (last_o)
  );

  // ---------------- editor model state ----------------
  logic [7:0] line_text [NSLOT][LINE_MAX];
  int         line_len [NSLOT];
  int         cur_slot;
  int         esc_phase;
  int         pend_pfx;
  int         pend_erase;
  edit_word_t step_words [$];   // words of the byte being modeled
  edit_word_t pending_words [$]; // words still due from the block

  int errors;
  int cycles;
  int bytes_sent;
  int words_seen;
  int idle_pct;
  int stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_words.size());
      $display("** console_line_editor_history_unit: FAILED **");
      $finish;
    end
  end

  // result stall, redrawn every falling edge
  always @(negedge clk_i) begin
    if (rst_ni) res_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------- model ----------------
  task automatic push_word(input int has, input int b, input int dst,
                           input int prm, input int nl);
    edit_word_t w;
    if (step_words.size() >= LINE_MAX) return;
    w.pfx   = pend_pfx[1:0];
    w.erase = pend_erase[6:0];
    w.has   = has[0];
    w.val   = has ? b[7:0] : 8'h00;
    w.dst   = has ? dst[1:0] : DstTerm;
    w.prm   = prm[0];
    w.nl    = nl[0];
    w.slot  = '0;
    w.last  = 1'b0;
    pend_pfx   = PfxNone;
    pend_erase = 0;
    step_words.push_back(w);
  endtask

  task automatic echo_slot(input int s);
    for (int i = 0; i < line_len[s]; i++) push_word(1, line_text[s][i], DstTerm, 0, 0);
  endtask

  // echo_mode: 0 nothing echoed yet, 1 final char still to echo, 2 all
  task automatic submit_line(input int echo_mode);
    int s;
    int n;
    int c;
    int dst;
    s = cur_slot;
    n = line_len[s];
    if (n == 2 && line_text[s][0] == ChBang) begin
      c = line_text[s][1];
      if (c >= ChZero && c < ChZero + NSLOT) s = c - ChZero;
      else if (c == ChBang) s = (s != 0) ? s - 1 : NSLOT - 1;
      cur_slot = s;
      n = line_len[s];
    end
    if (n != 0) begin
      for (int i = 0; i < n; i++) begin
        dst = (echo_mode == 2 || (echo_mode == 1 && i == n - 1)) ? DstBoth : DstQueue;
        push_word(1, line_text[s][i], dst, 0, i == n - 1);
      end
      s = (s + 1 < NSLOT) ? s + 1 : 0;
      cur_slot = s;
    end else begin
      push_word(0, 0, DstTerm, 1, 0);
    end
    line_len[s] = 0;
    esc_phase = EscNone;
  endtask

  task automatic model_byte(input logic [7:0] c);
    int cur;
    int len;
    int ns;
    int n;
    bit taken;
    bit seen_sp;
    edit_word_t w;
    step_words.delete();
    pend_pfx   = PfxNone;
    pend_erase = 0;
    taken = 0;
    cur = cur_slot;
    len = line_len[cur];
    if (esc_phase == EscSeen) begin
      esc_phase = EscNone;
      if (c == ChLbr) begin
        esc_phase = EscBrkt;
        taken = 1;
      end
    end else if (esc_phase == EscBrkt) begin
      esc_phase = EscNone;
      if (c == ChUp || c == ChDown) begin
        if (c == ChUp) ns = (cur != 0) ? cur - 1 : NSLOT - 1;
        else ns = (cur + 1 < NSLOT) ? cur + 1 : 0;
        if (len != 0) begin
          pend_pfx   = PfxErase;
          pend_erase = len;
        end
        cur_slot = ns;
        if (line_len[ns] >= LINE_MAX) submit_line(2);
        else echo_slot(ns);
        taken = 1;
      end
    end else if (c == ChEsc) begin
      esc_phase = EscSeen;
      taken = 1;
    end

    if (!taken) begin
      if (c == ChLf || c == ChRet) begin
        submit_line(0);
      end else if (c == ChBs || c == ChDel) begin
        if (len != 0) begin
          line_len[cur] = len - 1;
          pend_pfx   = PfxErase;
          pend_erase = 1;
        end
      end else if (c == ChCw) begin
        // trailing word, then the spaces in front of it; only trailing spaces if the line ends in one
        seen_sp = 0;
        n = 0;
        while (len > 0) begin
          if (seen_sp && line_text[cur][len-1] != ChSpace) break;
          if (line_text[cur][len-1] == ChSpace) seen_sp = 1;
          len--;
          n++;
        end
        line_len[cur] = len;
        if (n != 0) begin
          pend_pfx   = PfxErase;
          pend_erase = n;
        end
      end else if (c == ChCu) begin
        line_len[cur] = 0;
        if (len != 0) begin
          pend_pfx   = PfxErase;
          pend_erase = len;
        end
      end else if (c == ChCr) begin
        pend_pfx = PfxReprint;
        echo_slot(cur);
      end else if (c == ChCc) begin
        line_len[cur] = 0;
        pend_pfx = PfxCancel;
        submit_line(0);
      end else if (c >= ChSpace && c <= ChTilde) begin
        if (len < LINE_MAX) begin
          line_text[cur][len] = c;
          len++;
          line_len[cur] = len;
        end
        if (len >= LINE_MAX) submit_line(1);
        else push_word(1, c, DstTerm, 0, 0);
      end
    end
    if (pend_pfx != PfxNone) push_word(0, 0, DstTerm, 0, 0);

    foreach (step_words[k]) begin
      w = step_words[k];
      w.slot = cur_slot[2:0];
      w.last = (k == step_words.size() - 1);
      step_words[k] = w;
      pending_words.push_back(w);
    end
  endtask

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    forever begin
      @(posedge clk_i);
      if (!rx_stall_o) break;
    end
    model_byte(b);
    bytes_sent++;
  endtask

  task automatic send_esc_move(input bit up);
    send_byte(ChEsc);
    send_byte(ChLbr);
    send_byte(up ? ChUp : ChDown);
  endtask

  // a line of random text with occasional edits, then submit
  task automatic send_typed_line();
    int n;
    int r;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) send_byte(ChSpace);
      else if (r < 20) send_byte(($urandom_range(0, 1) != 0) ? ChBs : ChDel);
      else if (r < 23) send_byte(ChCw);
      else if (r < 25) send_byte(ChCu);
      else send_byte(8'($urandom_range(32, 126)));
    end
    send_byte(($urandom_range(0, 1) != 0) ? ChRet : ChLf);
  endtask

  // ---------------- checking ----------------
  task automatic cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    edit_word_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got byte %02h prefix %0d",
                 $time, byte_value_o, prefix_o);
      end else begin
        e = pending_words.pop_front();
        cmp_field("prefix", e.pfx, prefix_o);
        cmp_field("erase_count", e.erase, erase_count_o);
        cmp_field("has_byte", e.has, has_byte_o);
        cmp_field("byte_value", e.val, byte_value_o);
        cmp_field("destination", e.dst, destination_o);
        cmp_field("prompt_after", e.prm, prompt_after_o);
        cmp_field("newline_after", e.nl, newline_after_o);
        cmp_field("slot", e.slot, slot_o);
        cmp_field("last", e.last, last_o);
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int kind;
    int phase;
    int n;
    errors      = 0;
    cycles      = 0;
    bytes_sent  = 0;
    words_seen  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    cur_slot    = 0;
    esc_phase   = EscNone;
    foreach (line_len[i]) line_len[i] = 0;
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    res_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, no idling; typed rows check the model's words for that byte
    for (int i = 0; i < NDIR; i++) begin
      send_byte(dir_tab[i].b);
      if (dir_tab[i].cnt >= 0) begin
        n = step_words.size();
        if (n != dir_tab[i].cnt ||
            (n > 0 && (step_words[0].pfx != dir_tab[i].pfx ||
                       step_words[0].has != dir_tab[i].has ||
                       step_words[0].val != dir_tab[i].val))) begin
          errors++;
          $display("%0t: row %0d model disagrees, expected %0d words, got %0d",
                   $time, i, dir_tab[i].cnt, n);
        end
      end
    end
    send_byte(ChRet);

    // random part: phases rotate through the idling mixes
    while (bytes_sent < NDIR + RANDOM_ITEMS) begin
      phase = ((bytes_sent - NDIR) / 50) % 5;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        3: begin idle_pct = 18; stall_pct = 18; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_typed_line();
      end else if (kind < 60) begin
        // walk history, maybe edit the recalled line, then submit
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_esc_move($urandom_range(0, 1) != 0);
        if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(32, 126)));
        send_byte(ChRet);
      end else if (kind < 72) begin
        // recall forms: "!d" (digits past the ring too) or "!!"
        send_byte(ChBang);
        if ($urandom_range(0, 2) == 0) send_byte(ChBang);
        else send_byte(8'(ChZero + $urandom_range(0, 9)));
        send_byte(ChRet);
      end else if (kind < 77) begin
        // fill a line to the limit, occasionally walk back onto it
        for (int i = 0; i < LINE_MAX; i++) send_byte(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 1) != 0) send_esc_move(1'b1);
      end else if (kind < 85) begin
        send_byte(8'($urandom_range(32, 126)));
        send_byte(($urandom_range(0, 1) != 0) ? ChCr : ChCc);
      end else if (kind < 92) begin
        // broken escapes
        send_byte(ChEsc);
        if ($urandom_range(0, 1) != 0) send_byte(ChLbr);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d bytes sent, %0d result words checked over four idling mixes",
             bytes_sent, words_seen);
    $display("covered edits, escapes, history moves, recalls and full lines");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("** console_line_editor_history_unit: PASSED **");
    end else begin
      $display("** console_line_editor_history_unit: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
